### rtl/core/setl_pkg.sv
// shared types and constants for the sorted expiry timer list
package setl_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] RC_ARMED    = 3'd0;
  localparam logic [2:0] RC_RESCHED  = 3'd1;
  localparam logic [2:0] RC_REFUSED  = 3'd2;
  localparam logic [2:0] RC_REMOVED  = 3'd3;
  localparam logic [2:0] RC_NOT_LIST = 3'd4;
  localparam logic [2:0] RC_IGNORED  = 3'd5;
  localparam logic [2:0] RC_EXPIRED  = 3'd6;
  localparam logic [2:0] RC_NONE_DUE = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_ARMED   = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_REMOVED = 2'd3
  } entry_st_t;

  // request from sequencer to the shared deadline comparator
  typedef struct packed {
    logic [TIME_BITS_DEF-1:0] a;
    logic [TIME_BITS_DEF-1:0] b;
  } cmp_req_t;

endpackage

### rtl/core/setl_cmp.sv
// shared comparator: registered a > b on deadline words
module setl_cmp #(
  parameter int TIME_BITS = setl_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  output logic                 gt
);
  import setl_pkg::*;

  // one wide compare per cycle, registered
  always_ff @(posedge clk) begin
    gt <= (a > b);
  end
endmodule

### rtl/core/sorted_expiry_timer_list.sv
// top level: sorted expiry timer list with a linked-list walk sequencer
//
//  channel | signals                                       | dir
//  in      | in_valid in_ready opcode handle interval now_ticks | input word
//  out     | out_valid out_ready code out_handle last        | result word
//
// insert/update walk the list from the tail, passing each entry through a link
// memory read, the shared comparator and a step toward the head.
// remove gives its result from the unlink state after the handle check; a tick
// examines entries from the head, and holds each expiry back one step for last.
// after reset a clearing pass sets every status to idle.
// each result waits in an output register; the sequencer stalls on out_ready.
module sorted_expiry_timer_list
  import setl_pkg::*;
#(
  parameter int ENTRIES   = setl_pkg::ENTRIES_DEF,
  parameter int TIME_BITS = setl_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [5:0]  handle,
  input  logic [30:0] interval,
  input  logic [31:0] now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  code,
  output logic [5:0]  out_handle,
  output logic        last
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = ((TIME_BITS > 31) ? TIME_BITS : 31) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CHECK  = 12'b000000000010,
    S_UNLINK = 12'b000000000100,
    S_SUM    = 12'b000000001000,
    S_RDTAIL = 12'b000000010000,
    S_CMP    = 12'b000000100000,
    S_LINK   = 12'b000001000000,
    S_FIX    = 12'b000010000000,
    S_TRD    = 12'b000100000000,
    S_TCMP   = 12'b001000000000,
    S_OUT    = 12'b010000000000,
    S_CLR    = 12'b100000000000
  } state_t;

  state_t state;

  // link and deadline memories
  logic [TIME_BITS-1:0] dl_mem [ENTRIES];
  logic [IW:0] nx_mem [ENTRIES];
  logic [IW:0] pv_mem [ENTRIES];
  entry_st_t   status [ENTRIES];

  logic [IW:0] head, tail;
  logic [TIME_BITS-1:0] cur_time;

  // latched word
  logic [1:0]  op;
  logic [5:0]  hnd;
  logic [30:0] ivl;
  logic [TIME_BITS-1:0] new_dl;
  logic [IW-1:0] hi;
  logic [IW:0] p;          // walk pointer
  logic [IW:0] p_prev, p_next;
  logic          any_exp;
  logic [5:0]    hold_h;
  logic          pend_tail_fix;
  logic [IW-1:0] clr_idx;

  // memory read port
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_sel;
  logic [TIME_BITS-1:0] rd_dl;
  logic [IW:0] rd_nx, rd_pv;
  entry_st_t   rd_st;

  logic cmp_gt;
  logic [TIME_BITS-1:0] cmp_a, cmp_b;

  setl_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
    .clk(clk), .a(cmp_a), .b(cmp_b), .gt(cmp_gt)
  );

  function automatic logic is_ent(logic [IW:0] v);
    return v < (IW+1)'(ENTRIES);
  endfunction

  logic hnd_ok;
  assign hnd_ok = {1'b0, hnd} < 7'(ENTRIES);
  assign hi = hnd[IW-1:0];

  // operand mux for the comparator
  always_comb begin
    cmp_a = rd_dl;
    cmp_b = new_dl;
    if (op == OP_TICK) begin
      cmp_a = rd_dl;
      cmp_b = cur_time;
    end
  end

  // read address follows the incoming handle while idle
  assign rd_sel = (state == S_IDLE) ? handle[IW-1:0] : rd_addr;

  // registered memory reads
  always_ff @(posedge clk) begin
    rd_dl <= dl_mem[rd_sel];
    rd_nx <= nx_mem[rd_sel];
    rd_pv <= pv_mem[rd_sel];
    rd_st <= status[rd_sel];
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  logic [TIME_BITS-1:0] tv;
  logic [SW-1:0] sum;
  assign tv  = TIME_BITS'(now_ticks);
  assign sum = SW'(cur_time) + SW'(ivl);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      head      <= '1;
      tail      <= '1;
      cur_time  <= '0;
      out_valid <= 1'b0;
      clr_idx   <= '0;
      rd_addr   <= '0;
      any_exp   <= 1'b0;
      pend_tail_fix <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          // one status entry per cycle back to idle
          status[clr_idx] <= ST_IDLE;
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op  <= opcode;
            hnd <= handle;
            ivl <= interval;
            any_exp <= 1'b0;
            if (opcode == OP_TICK) begin
              cur_time <= tv;
              state <= S_TRD;
            end else begin
              rd_addr <= handle[IW-1:0];
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // rd_* now holds the handle's links and status
          if (out_free) begin
            code <= RC_REFUSED; out_handle <= hnd; last <= 1'b1;
            p_prev <= rd_pv; p_next <= rd_nx;
            unique case (op)
              OP_INSERT: begin
                if (!hnd_ok || rd_st != ST_IDLE) begin
                  code <= RC_REFUSED; out_valid <= 1'b1; state <= S_IDLE;
                end else begin
                  code <= RC_ARMED; state <= S_SUM;
                end
              end
              OP_REMOVE: begin
                if (!hnd_ok || rd_st != ST_ARMED) begin
                  code <= RC_NOT_LIST; out_valid <= 1'b1; state <= S_IDLE;
                end else state <= S_UNLINK;
              end
              default: begin
                if (!hnd_ok || rd_st == ST_EXPIRED ||
                    rd_st == ST_REMOVED) begin
                  code <= RC_IGNORED; out_valid <= 1'b1; state <= S_IDLE;
                end else if (rd_st == ST_ARMED) begin
                  code <= RC_RESCHED; state <= S_UNLINK;
                end else begin
                  code <= RC_ARMED; state <= S_SUM;
                end
              end
            endcase
          end
        end
        S_UNLINK: begin
          if (is_ent(p_prev)) nx_mem[p_prev[IW-1:0]] <= p_next;
          else head <= p_next;
          if (is_ent(p_next)) pv_mem[p_next[IW-1:0]] <= p_prev;
          else tail <= p_prev;
          if (op == OP_REMOVE) begin
            status[hi] <= ST_REMOVED;
            dl_mem[hi] <= '0;
            code <= RC_REMOVED; out_valid <= 1'b1; state <= S_IDLE;
          end else state <= S_SUM;
        end
        S_SUM: begin
          new_dl <= (sum > SW'(TMAX)) ? TMAX : sum[TIME_BITS-1:0];
          p <= tail;
          rd_addr <= tail[IW-1:0];
          state <= S_RDTAIL;
        end
        S_RDTAIL: begin
          // read lands this cycle; compare next
          state <= is_ent(p) ? S_CMP : S_LINK;
        end
        S_CMP: begin
          // rd_dl valid; comparator registers rd_dl > new_dl
          p_prev <= rd_pv;
          p_next <= rd_nx;
          state <= S_FIX;
        end
        S_FIX: begin
          if (cmp_gt) begin
            p <= p_prev;
            rd_addr <= p_prev[IW-1:0];
            state <= S_RDTAIL;
          end else state <= S_LINK;
        end
        S_LINK: begin
          // insert after p, or at the head when p is null
          if (is_ent(p)) begin
            nx_mem[hi] <= p_next;
            nx_mem[p[IW-1:0]] <= {1'b0, hi};
            if (is_ent(p_next)) pv_mem[p_next[IW-1:0]] <= {1'b0, hi};
            else tail <= {1'b0, hi};
          end else begin
            nx_mem[hi] <= head;
            head <= {1'b0, hi};
            if (is_ent(head)) pv_mem[head[IW-1:0]] <= {1'b0, hi};
            else tail <= {1'b0, hi};
          end
          pv_mem[hi] <= is_ent(p) ? p : '1;
          dl_mem[hi] <= new_dl;
          status[hi] <= ST_ARMED;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_TRD: begin
          rd_addr <= head[IW-1:0];
          state <= is_ent(head) ? S_TCMP : S_OUT;
          pend_tail_fix <= 1'b0;
        end
        S_TCMP: begin
          // wait for read data, then comparator
          pend_tail_fix <= 1'b1;
          if (pend_tail_fix) begin
            pend_tail_fix <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (is_ent(head) && !cmp_gt && pend_tail_fix == 1'b0 &&
                rd_addr == head[IW-1:0]) begin
              // head entry is due; send the one held back, hold this one
              status[head[IW-1:0]] <= ST_EXPIRED;
              dl_mem[head[IW-1:0]] <= '0;
              if (any_exp) begin
                code <= RC_EXPIRED; out_handle <= hold_h; last <= 1'b0;
                out_valid <= 1'b1;
              end
              hold_h <= 6'(head);
              any_exp <= 1'b1;
              head <= rd_nx;
              rd_addr <= rd_nx[IW-1:0];
              state <= is_ent(rd_nx) ? S_TCMP : S_OUT;
            end else begin
              if (is_ent(head)) pv_mem[head[IW-1:0]] <= '1;
              else tail <= '1;
              // held expiry or none due closes the tick
              code <= any_exp ? RC_EXPIRED : RC_NONE_DUE;
              out_handle <= any_exp ? hold_h : 6'd0;
              last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the block takes no word while a result is still being built
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  // a stalled result holds its code
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(code) || $past(state) == S_OUT)
    else $error("result changed under stall");
  // empty list has both ends null
  a_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !is_ent(head)) |-> !is_ent(tail))
    else $error("list ends disagree");
`endif
endmodule
